// ----- design/assert_macros.svh -----
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/gbmf_pkg.sv -----
// shared types and constants for the block median filter
package gbmf_pkg;

  // samples per capture window
  localparam int WINDOW = 5;
  // position of the median in the sorted row
  localparam int MID = WINDOW / 2;
  // sample counter width, holds 0 .. WINDOW-1
  localparam int CNT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  // input kind codes carried on tuser
  localparam logic OP_ARM    = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // stored sample, latitude sign-extended to this width
  typedef logic signed [31:0] samp_t;

  // what one cell hands its right-hand neighbour
  typedef struct packed {
    logic  less;   // new sample sorts below this cell's value
    samp_t val;    // held value
    logic  vld;    // cell holds a sample of the current capture
  } cell_link_t;

endpackage

// ----- design/gps_block_median_filter.sv -----
// top level of the block median filter for position samples
// An arm transfer (tuser = 0) starts a capture; while armed, each sample transfer
// (tuser = 1) is inserted into two rows of sorting cells, one for latitude and one
// for longitude, one transfer per cycle. When WINDOW samples have been taken the
// median latitude and median longitude appear on the output in the cycle after the
// last sample, and the block disarms; samples outside a capture are dropped.
// The cell rows take a new sample on every accepted transfer, so input runs at one transfer
// per cycle; the input stalls only while a finished result waits to be taken.
`include "assert_macros.svh"

module gps_block_median_filter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // lat_fix [30:0], lon_fix [62:31], zero [63]
  input  logic        s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // median_lat [30:0], median_lon [62:31], zero [63]
);
  import gbmf_pkg::*;

  logic             s_xfer;
  logic             arm;
  logic             ins;
  logic             done;
  logic             armed;
  logic [CNT_W-1:0] cnt;
  samp_t            lat_in;
  samp_t            lon_in;
  samp_t            lat_mid;
  samp_t            lon_mid;
  logic [30:0]      med_lat;
  logic [31:0]      med_lon;

  // input handshake, output register frees the input
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign arm           = s_xfer && (s_axis_tuser == OP_ARM);
  assign ins           = s_xfer && (s_axis_tuser == OP_SAMPLE) && armed;
  assign done          = ins && (cnt == CNT_W'(WINDOW - 1));

  // field unpacking
  assign lat_in = {s_axis_tdata[30], s_axis_tdata[30:0]};
  assign lon_in = s_axis_tdata[62:31];

  // capture control
  always_ff @(posedge clk) begin
    if (rst) begin
      armed <= 1'b0;
      cnt   <= '0;
    end else if (arm) begin
      armed <= 1'b1;
      cnt   <= '0;
    end else if (done) begin
      armed <= 1'b0;
      cnt   <= '0;
    end else if (ins) begin
      cnt   <= cnt + CNT_W'(1);
    end
  end

  // sort rows
  gbmf_row u_lat_row (
    .clk      (clk),
    .rst      (rst),
    .clr      (arm),
    .ins      (ins),
    .new_val  (lat_in),
    .mid_next (lat_mid)
  );

  gbmf_row u_lon_row (
    .clk      (clk),
    .rst      (rst),
    .clr      (arm),
    .ins      (ins),
    .new_val  (lon_in),
    .mid_next (lon_mid)
  );

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (done) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (done) begin
      med_lat <= lat_mid[30:0];
      med_lon <= lon_mid;
    end
  end

  assign m_axis_tdata = {1'b0, med_lon, med_lat};

  // checks
  `ASSERT_NEXT(a_done_gives_result, done, m_axis_tvalid)
  `ASSERT_SAME(a_idle_count_zero, !armed, cnt == '0)
  `ASSERT_SAME(a_count_in_window, 1'b1, cnt <= CNT_W'(WINDOW - 1))
  `ASSERT_NEXT(a_result_needs_done, !m_axis_tvalid && !done, !m_axis_tvalid)

endmodule

// ----- design/gbmf_cell.sv -----
// one insertion-sort cell: keeps, takes the new sample or takes its left neighbour
module gbmf_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                clr,
  input  logic                ins,
  input  gbmf_pkg::samp_t     new_val,
  input  gbmf_pkg::cell_link_t left,
  output gbmf_pkg::cell_link_t right,
  output gbmf_pkg::samp_t     val_next
);
  import gbmf_pkg::*;

  samp_t val;
  logic  vld;
  logic  vld_next;
  logic  less;

  // empty cells count as above every sample
  assign less = !vld || (new_val < val);

  // shift right when the sample lands further left, else insert or hold
  always_comb begin
    if (left.less) begin
      val_next = left.val;
      vld_next = left.vld;
    end else if (less) begin
      val_next = new_val;
      vld_next = 1'b1;
    end else begin
      val_next = val;
      vld_next = vld;
    end
  end

  // valid flag, cleared on a new capture
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (clr) begin
      vld <= 1'b0;
    end else if (ins) begin
      vld <= vld_next;
    end
  end

  // held value
  always_ff @(posedge clk) begin
    if (ins) begin
      val <= val_next;
    end
  end

  assign right = '{less: less, val: val, vld: vld};

endmodule

// ----- design/gbmf_row.sv -----
// row of sort cells for one coordinate, gives the next median value
module gbmf_row (
  input  logic            clk,
  input  logic            rst,
  input  logic            clr,
  input  logic            ins,
  input  gbmf_pkg::samp_t new_val,
  output gbmf_pkg::samp_t mid_next
);
  import gbmf_pkg::*;

  cell_link_t link [WINDOW];
  samp_t      nxt  [WINDOW];

  // ascending chain, lowest value in cell zero
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    cell_link_t left_in;
    if (i == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_rest
      assign left_in = link[i-1];
    end
    gbmf_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .clr      (clr),
      .ins      (ins),
      .new_val  (new_val),
      .left     (left_in),
      .right    (link[i]),
      .val_next (nxt[i])
    );
  end

  assign mid_next = nxt[MID];

endmodule

// ----- verif/testbench.sv -----
// testbench for the block median filter: directed and random captures, scoreboard checks
`timescale 1ns / 1ps

// predicts median results from accepted transfers and checks the output stream
class median_scoreboard;
  typedef gbmf_pkg::samp_t row_t [gbmf_pkg::WINDOW];
  typedef struct packed {
    logic [30:0] lat;
    logic [31:0] lon;
  } median_t;

  row_t      lat_row;
  row_t      lon_row;
  int        fill;
  bit        armed;
  median_t   median_q[$];
  int        errors;

  function new();
    fill   = 0;
    armed  = 0;
    errors = 0;
  endfunction

  // signed middle element of a sorted copy of the row
  function gbmf_pkg::samp_t middle_of(row_t row);
    row_t            buf_row;
    gbmf_pkg::samp_t key;
    int              j;
    buf_row = row;
    for (int i = 1; i < gbmf_pkg::WINDOW; i++) begin
      key = buf_row[i];
      j   = i - 1;
      while (j >= 0 && buf_row[j] > key) begin
        buf_row[j + 1] = buf_row[j];
        j--;
      end
      buf_row[j + 1] = key;
    end
    return buf_row[gbmf_pkg::MID];
  endfunction

  // accepted input transfer
  function void note_input(logic op, logic [30:0] lat, logic [31:0] lon);
    median_t m;
    gbmf_pkg::samp_t mlat;
    if (op == gbmf_pkg::OP_ARM) begin
      armed = 1;
      fill  = 0;
      return;
    end
    if (!armed) return;
    lat_row[fill] = {lat[30], lat};
    lon_row[fill] = lon;
    fill++;
    if (fill == gbmf_pkg::WINDOW) begin
      mlat  = middle_of(lat_row);
      m.lat = mlat[30:0];
      m.lon = middle_of(lon_row);
      median_q.push_back(m);
      fill  = 0;
      armed = 0;
    end
  endfunction

  // accepted output transfer
  function void check_result(logic [63:0] data);
    median_t m;
    if (median_q.size() == 0) begin
      $error("unexpected result: median_lat %0d median_lon %0d",
             $signed(data[30:0]), $signed(data[62:31]));
      errors++;
      return;
    end
    m = median_q.pop_front();
    if (data[30:0] !== m.lat) begin
      $error("median_lat mismatch: expected %0d, actual %0d",
             $signed(m.lat), $signed(data[30:0]));
      errors++;
    end
    if (data[62:31] !== m.lon) begin
      $error("median_lon mismatch: expected %0d, actual %0d",
             $signed(m.lon), $signed(data[62:31]));
      errors++;
    end
  endfunction

  function int pending();
    return median_q.size();
  endfunction
endclass

module testbench;
  import gbmf_pkg::*;

  localparam int ITEM_COUNT = 750;
  localparam int IDLE_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        s_axis_tuser = OP_ARM;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;

  median_scoreboard sb;

  int          burst_left = 0;
  int          sent_count = 0;
  int          idle_cycles = 0;
  logic [30:0] lat_base;
  logic [31:0] lon_base;

  // receiver stall pattern state
  int          rx_mode = 0;
  int          rx_left = 0;
  int unsigned rx_phase = 0;

  gps_block_median_filter u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  // receiver: switches between always ready, random, mostly stalled and periodic
  always @(posedge clk) begin
    logic rdy;
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(10, 60);
    end
    rx_left--;
    rx_phase++;
    case (rx_mode)
      0:       rdy = 1'b1;
      1:       rdy = 1'($urandom_range(0, 1));
      2:       rdy = ($urandom_range(0, 3) == 0);
      default: rdy = rx_phase[1];
    endcase
    m_axis_tready <= rdy;
  end

  // monitor: inputs change only at the rising edge, so handshakes are settled here
  always @(negedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_input(s_axis_tuser, s_axis_tdata[30:0], s_axis_tdata[62:31]);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata);
      // watchdog on cycles without any transfer
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // one input transfer, with bursts and random gaps between them
  task automatic send_item(input logic op, input logic [30:0] lat, input logic [31:0] lon);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {1'b0, lon, lat};
    do @(negedge clk); while (!s_axis_tready);
    @(posedge clk);
  endtask

  function automatic logic [30:0] pick_lat();
    case ($urandom_range(0, 5))
      0, 1:    return 31'(int'($urandom_range(0, 1800000000)) - 900000000);
      2:       return 31'($urandom());
      3: begin
        case ($urandom_range(0, 4))
          0:       return 31'h4000_0000;
          1:       return 31'h3FFF_FFFF;
          2:       return '1;
          3:       return '0;
          default: return 31'd1;
        endcase
      end
      default: return lat_base + 31'($urandom_range(0, 8)) - 31'd4;
    endcase
  endfunction

  function automatic logic [31:0] pick_lon();
    case ($urandom_range(0, 5))
      0, 1:    return 32'(longint'($urandom_range(0, 32'd3600000000)) - 64'sd1800000000);
      2:       return $urandom();
      3: begin
        case ($urandom_range(0, 4))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return '1;
          3:       return '0;
          default: return 32'd1;
        endcase
      end
      default: return lon_base + 32'($urandom_range(0, 8)) - 32'd4;
    endcase
  endfunction

  // arm followed by n samples of random content
  task automatic send_capture(input int n);
    lat_base = pick_lat();
    lon_base = pick_lon();
    send_item(OP_ARM, '0, '0);
    for (int i = 0; i < n; i++)
      send_item(OP_SAMPLE, pick_lat(), pick_lon());
    sent_count += n + 1;
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // sample with no capture in progress is dropped
    send_item(OP_SAMPLE, 31'h3FFF_FFFF, 32'h8000_0000);
    // field extremes in one window, median of both is zero
    send_item(OP_ARM, '0, '0);
    send_item(OP_SAMPLE, 31'h3FFF_FFFF, 32'h8000_0000);
    send_item(OP_SAMPLE, 31'h4000_0000, 32'h7FFF_FFFF);
    send_item(OP_SAMPLE, '0, '0);
    send_item(OP_SAMPLE, '1, '1);
    send_item(OP_SAMPLE, 31'd1, 32'd1);
    // block has disarmed after the result
    send_item(OP_SAMPLE, 31'd77, 32'd77);
    // re-arm mid capture discards the partial window; hemispheres mixed
    send_item(OP_ARM, '0, '0);
    send_item(OP_SAMPLE, 31'd5, 32'd5);
    send_item(OP_SAMPLE, 31'd6, 32'd6);
    send_item(OP_ARM, '0, '0);
    send_item(OP_SAMPLE, 31'(900000000), 32'(1800000000));
    send_item(OP_SAMPLE, 31'(-900000000), 32'(-1800000000));
    send_item(OP_SAMPLE, 31'(123), 32'(-456));
    send_item(OP_SAMPLE, 31'(-456), 32'(123));
    send_item(OP_SAMPLE, 31'(899999999), 32'(-1799999999));
    // double arm, then a window of identical samples
    send_item(OP_ARM, '0, '0);
    send_item(OP_ARM, '0, '0);
    for (int i = 0; i < 5; i++)
      send_item(OP_SAMPLE, 31'(-315000000), 32'(1152000000));

    // random captures, mostly well formed
    while (sent_count < ITEM_COUNT) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: send_capture(WINDOW);
        7: send_capture($urandom_range(1, WINDOW - 1));
        8: begin
          // stray samples, dropped unless a broken capture left the block armed
          repeat ($urandom_range(1, 3)) send_item(OP_SAMPLE, pick_lat(), pick_lon());
        end
        default: begin
          send_item(OP_ARM, '0, '0);
          sent_count++;
          send_capture(WINDOW);
        end
      endcase
    end
    s_axis_tvalid <= 1'b0;

    // drain outstanding results, then allow for the output latency
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+design
design/gbmf_pkg.sv
design/gbmf_cell.sv
design/gbmf_row.sv
design/gps_block_median_filter.sv
verif/testbench.sv
